// ----- hw/rtl/i2cee_pkg.sv -----
// Package with payload types and constants for the I2C EEPROM master.
`default_nettype none
package i2cee_pkg;
  typedef struct packed {
    logic [1:0]  mode;
    logic        scl_in;
    logic        sda_in;
    logic [10:0] mem_address;
    logic [4:0]  byte_count;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       busy_res;
    logic       done_res;
    logic       failed;
  } out_item_t;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [2:0] REG_DEVICE_BASE = 3'd0;
  localparam logic [2:0] REG_HOLD        = 3'd1;
  localparam logic [2:0] REG_GAP         = 3'd2;
  localparam logic [2:0] REG_WWAIT       = 3'd3;
  localparam logic [2:0] REG_ATTEMPTS    = 3'd4;

  localparam int unsigned MAX_LEN = 16;
endpackage
`default_nettype wire

// ----- hw/rtl/i2cee_ram.sv -----
// Generic single-port-write RAM with registered read.
`default_nettype none
module i2cee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/i2cee_cfg.sv -----
// Configuration register file for the I2C EEPROM master.
`default_nettype none
module i2cee_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic [7:0]       device_base,
  output logic [7:0]       hold_ticks,
  output logic [7:0]       gap_ticks,
  output logic [15:0]      write_wait_ticks,
  output logic [3:0]       max_attempts
);
  import i2cee_pkg::*;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_base <= 8'd160;
      hold_ticks <= 8'd12;
      gap_ticks <= 8'd20;
      write_wait_ticks <= 16'd7000;
      max_attempts <= 4'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEVICE_BASE: device_base <= cfg_data[7:0];
        REG_HOLD:        hold_ticks <= cfg_data[7:0];
        REG_GAP:         gap_ticks <= cfg_data[7:0];
        REG_WWAIT:       write_wait_ticks <= cfg_data;
        REG_ATTEMPTS:    max_attempts <= cfg_data[3:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/i2c_eeprom_master_top.sv -----
// Each input beat passes the input register stage; its result beat is then registered in the output slots for out_.
// Throughput: one input beat per cycle; in_ready drops only while both output slots
// would be occupied with out_ready low.
// The buffer byte for each data phase is prefetched from a registered-read RAM.
// Reset (rst_n low, synchronous) idles the bus sequencer with both lines released.
// The write buffer contents are undefined until loaded; no clearing pass is run.
`default_nettype none
module i2c_eeprom_master_top #(
  parameter int PAGE_BYTES   = 16,
  parameter int BUFFER_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire i2cee_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output i2cee_pkg::out_item_t    out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import i2cee_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int PW = $clog2(PAGE_BYTES);
  localparam int FW = $clog2(BUFFER_DEPTH + 1);
  localparam int DEPTH_LEN = (BUFFER_DEPTH < MAX_LEN) ? BUFFER_DEPTH : MAX_LEN;

  typedef enum logic [4:0] {
    P_IDLE, P_STOP_A, P_STOP_B, P_STOP_C, P_STOP_D, P_GAP, P_START_A, P_START_B,
    P_TX_BIT, P_TX_HI, P_TX_LO, P_ACK_A, P_ACK_B, P_ACK_C, P_ACK_D, P_RX_PREP,
    P_RX_A, P_RX_B, P_RX_C, P_RA_A, P_RA_B, P_RA_C, P_WWAIT, P_FINISH
  } phase_t;
  typedef enum logic [1:0] {S_ID, S_ADDR, S_DATA, S_RID} stage_t;
  typedef enum logic [2:0] {W_BEGIN, W_REREAD, W_PAGE, W_DONE, W_FAIL} why_t;

  logic [7:0] device_base, hold_ticks, gap_ticks;
  logic [15:0] write_wait_ticks;
  logic [3:0] max_attempts;

  assign cfg_ready = 1'b1;
  i2cee_cfg u_cfg (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .device_base, .hold_ticks, .gap_ticks, .write_wait_ticks, .max_attempts
  );

  // Input register stage.
  logic     s1_valid_r;
  in_item_t s1_r;
  // Output slots: main register and skid.
  logic      o_valid_r, k_valid_r;
  out_item_t o_r, k_r, res;

  assign in_ready  = !k_valid_r && !(s1_valid_r && o_valid_r && !out_ready);
  assign out_valid = o_valid_r;
  assign out_data  = o_r;

  // Sequencer state.
  phase_t phase_r, resume_r;
  stage_t stage_r;
  why_t   purpose_r;
  logic [3:0]  bit_index_r, attempt_r;
  logic [7:0]  shift_r;
  logic [FW-1:0] fill_r;
  logic [4:0]  byte_index_r, remaining_r, page_len_r;
  logic [10:0] addr_r;
  logic [15:0] wait_r;
  logic [8:0]  buf_base_r;
  logic scl_r, sda_r, stretch_r, is_read_r, fail_r, nack_r;

  // Prefetched buffer byte for the next data phase.
  logic [8:0] rd_idx;
  logic [7:0] ram_q;
  logic       rd_in_range_r;
  logic [8:0] idx_nxt_full;
  logic       we;

  phase_t phase_nxt, resume_nxt;
  stage_t stage_nxt;
  why_t   purpose_nxt;
  logic [3:0] bit_index_nxt, attempt_nxt;
  logic [7:0] shift_nxt;
  logic [FW-1:0] fill_nxt;
  logic [4:0] byte_index_nxt, remaining_nxt, page_len_nxt;
  logic [10:0] addr_nxt;
  logic [15:0] wait_nxt;
  logic [8:0] buf_base_nxt;
  logic scl_nxt, sda_nxt, stretch_nxt, is_read_nxt, fail_nxt, nack_nxt;

  function automatic logic [15:0] hold_of(input logic [15:0] v);
    return (v == 16'd0) ? 16'd0 : v - 16'd1;
  endfunction

  logic [7:0] buf_byte;
  assign buf_byte = rd_in_range_r ? ram_q : 8'd0;

  logic [4:0] len;
  logic [PW:0] page_room;
  logic [4:0]  page_calc;
  logic [3:0]  att_lim;
  logic [7:0]  dev_id;
  logic        run;

  always_comb begin
    phase_nxt = phase_r; resume_nxt = resume_r; stage_nxt = stage_r;
    purpose_nxt = purpose_r;
    bit_index_nxt = bit_index_r; attempt_nxt = attempt_r; shift_nxt = shift_r;
    fill_nxt = fill_r; byte_index_nxt = byte_index_r; remaining_nxt = remaining_r;
    page_len_nxt = page_len_r; addr_nxt = addr_r; wait_nxt = wait_r;
    buf_base_nxt = buf_base_r;
    scl_nxt = scl_r; sda_nxt = sda_r; stretch_nxt = stretch_r; is_read_nxt = is_read_r;
    fail_nxt = fail_r; nack_nxt = nack_r;
    res = '0;
    we = 1'b0;
    dev_id = '0;
    len = '0; page_room = '0; page_calc = '0;
    att_lim = (max_attempts == 4'd0) ? 4'd1 : max_attempts;
    run = (phase_r != P_IDLE);

    if (phase_r == P_IDLE) begin
      if (s1_r.mode == MODE_LOAD) begin
        if (fill_r < FW'(BUFFER_DEPTH)) begin
          we = 1'b1;
          fill_nxt = fill_r + FW'(1);
        end
      end else if (s1_r.mode == MODE_WRITE || s1_r.mode == MODE_READ) begin
        is_read_nxt = (s1_r.mode == MODE_READ);
        len = (s1_r.byte_count > 5'(MAX_LEN)) ? 5'(MAX_LEN) : s1_r.byte_count;
        if (!is_read_nxt && len > 5'(DEPTH_LEN)) len = 5'(DEPTH_LEN);
        fail_nxt = 1'b0; nack_nxt = 1'b0;
        addr_nxt = s1_r.mem_address;
        buf_base_nxt = '0; remaining_nxt = len; stretch_nxt = 1'b0; wait_nxt = '0;
        if (len == 5'd0) begin
          res.done_res = 1'b1;
          if (!is_read_nxt) fill_nxt = '0;
        end else begin
          if (is_read_nxt) page_len_nxt = len;
          else begin
            page_room = (PW+1)'(PAGE_BYTES) - {1'b0, addr_nxt[PW-1:0]};
            page_calc = (32'(page_room) > 32'(len)) ? len : 5'(page_room);
            page_len_nxt = page_calc;
          end
          attempt_nxt = 4'd1; byte_index_nxt = '0; purpose_nxt = W_BEGIN;
          phase_nxt = P_STOP_A;
          run = 1'b1;
        end
      end
    end

    if (run) begin
      if (stretch_r) begin
        if (s1_r.scl_in) begin
          stretch_nxt = 1'b0;
          wait_nxt = hold_of({8'd0, hold_ticks});
        end
      end else if (wait_nxt != 16'd0) begin
        wait_nxt = wait_nxt - 16'd1;
      end else begin
        dev_id = device_base + {4'd0, addr_nxt[10:8], 1'b0};
        unique case (phase_nxt)
          P_STOP_A: begin sda_nxt = 1'b1; wait_nxt = hold_of({8'd0, hold_ticks});
            phase_nxt = P_STOP_B; end
          P_STOP_B: begin sda_nxt = 1'b0; wait_nxt = hold_of({8'd0, hold_ticks});
            phase_nxt = P_STOP_C; end
          P_STOP_C: begin scl_nxt = 1'b1; wait_nxt = hold_of({8'd0, hold_ticks});
            phase_nxt = P_STOP_D; end
          P_STOP_D: begin
            sda_nxt = 1'b1; wait_nxt = hold_of({8'd0, hold_ticks});
            if (purpose_r == W_BEGIN || purpose_r == W_REREAD) begin
              resume_nxt = P_START_A; phase_nxt = P_GAP;
            end else if (purpose_r == W_PAGE) phase_nxt = P_WWAIT;
            else phase_nxt = P_FINISH;
          end
          P_GAP: begin wait_nxt = hold_of({8'd0, gap_ticks}); phase_nxt = resume_r; end
          P_START_A: begin sda_nxt = 1'b0; wait_nxt = hold_of({8'd0, hold_ticks});
            phase_nxt = P_START_B; end
          P_START_B: begin
            scl_nxt = 1'b0; wait_nxt = hold_of({8'd0, hold_ticks});
            bit_index_nxt = '0; phase_nxt = P_TX_BIT;
            if (purpose_r == W_REREAD) begin
              stage_nxt = S_RID; shift_nxt = dev_id | 8'd1;
            end else begin
              stage_nxt = S_ID; shift_nxt = dev_id;
            end
          end
          P_TX_BIT: begin
            sda_nxt = shift_r[7]; shift_nxt = {shift_r[6:0], 1'b0};
            wait_nxt = hold_of({8'd0, hold_ticks}); phase_nxt = P_TX_HI;
          end
          P_TX_HI: begin scl_nxt = 1'b1; stretch_nxt = 1'b1; phase_nxt = P_TX_LO; end
          P_TX_LO: begin
            scl_nxt = 1'b0; wait_nxt = hold_of({8'd0, hold_ticks});
            bit_index_nxt = bit_index_r + 4'd1;
            phase_nxt = (bit_index_nxt >= 4'd8) ? P_ACK_A : P_TX_BIT;
          end
          P_ACK_A: begin scl_nxt = 1'b0; wait_nxt = hold_of({8'd0, hold_ticks});
            phase_nxt = P_ACK_B; end
          P_ACK_B: begin sda_nxt = 1'b1; wait_nxt = hold_of({8'd0, hold_ticks});
            phase_nxt = P_ACK_C; end
          P_ACK_C: begin scl_nxt = 1'b1; stretch_nxt = 1'b1; phase_nxt = P_ACK_D; end
          P_ACK_D: begin
            scl_nxt = 1'b0; wait_nxt = hold_of({8'd0, hold_ticks});
            nack_nxt = s1_r.sda_in;
            if (s1_r.sda_in) begin
              if (attempt_r < att_lim) begin
                attempt_nxt = attempt_r + 4'd1; byte_index_nxt = '0;
                purpose_nxt = W_BEGIN; phase_nxt = P_STOP_A;
              end else begin
                fail_nxt = 1'b1; purpose_nxt = W_FAIL; phase_nxt = P_STOP_A;
              end
            end else begin
              unique case (stage_r)
                S_ID: begin
                  stage_nxt = S_ADDR; shift_nxt = addr_r[7:0];
                  bit_index_nxt = '0; phase_nxt = P_TX_BIT;
                end
                S_ADDR: begin
                  if (is_read_r) begin
                    purpose_nxt = W_REREAD; phase_nxt = P_STOP_A;
                  end else begin
                    stage_nxt = S_DATA; shift_nxt = buf_byte;
                    bit_index_nxt = '0; phase_nxt = P_TX_BIT;
                  end
                end
                S_DATA: begin
                  byte_index_nxt = byte_index_r + 5'd1;
                  if (byte_index_nxt < page_len_r) begin
                    shift_nxt = buf_byte; bit_index_nxt = '0; phase_nxt = P_TX_BIT;
                  end else begin
                    purpose_nxt = W_PAGE; resume_nxt = P_STOP_A; phase_nxt = P_GAP;
                  end
                end
                default: phase_nxt = P_RX_PREP;
              endcase
            end
          end
          P_RX_PREP: begin
            sda_nxt = 1'b0; scl_nxt = 1'b0; wait_nxt = '0; bit_index_nxt = '0;
            shift_nxt = '0;
            phase_nxt = P_RX_A;
          end
          P_RX_A: begin sda_nxt = 1'b1; wait_nxt = hold_of({8'd0, hold_ticks});
            phase_nxt = P_RX_B; end
          P_RX_B: begin scl_nxt = 1'b1; stretch_nxt = 1'b1; phase_nxt = P_RX_C; end
          P_RX_C: begin
            shift_nxt = {shift_r[6:0], s1_r.sda_in};
            scl_nxt = 1'b0; wait_nxt = hold_of({8'd0, hold_ticks});
            bit_index_nxt = bit_index_r + 4'd1;
            if (bit_index_nxt >= 4'd8) begin
              res.read_valid = 1'b1; res.read_byte = shift_nxt; phase_nxt = P_RA_A;
            end else phase_nxt = P_RX_A;
          end
          P_RA_A: begin
            sda_nxt = (remaining_r <= 5'd1); wait_nxt = hold_of({8'd0, hold_ticks});
            phase_nxt = P_RA_B;
          end
          P_RA_B: begin scl_nxt = 1'b1; stretch_nxt = 1'b1; phase_nxt = P_RA_C; end
          P_RA_C: begin
            scl_nxt = 1'b0; wait_nxt = '0;
            remaining_nxt = (remaining_r != 5'd0) ? remaining_r - 5'd1 : 5'd0;
            if (remaining_nxt != 5'd0) begin
              bit_index_nxt = '0; shift_nxt = '0; phase_nxt = P_RX_A;
            end else begin
              purpose_nxt = W_DONE; phase_nxt = P_STOP_A;
            end
          end
          P_WWAIT: begin
            wait_nxt = hold_of(write_wait_ticks);
            remaining_nxt = (remaining_r > page_len_r) ? remaining_r - page_len_r : 5'd0;
            addr_nxt = addr_r + {6'd0, page_len_r};
            buf_base_nxt = buf_base_r + {4'd0, page_len_r};
            if (remaining_nxt != 5'd0) begin
              page_room = (PW+1)'(PAGE_BYTES) - {1'b0, addr_nxt[PW-1:0]};
              page_calc = (32'(page_room) > 32'(remaining_nxt)) ?
                          remaining_nxt : 5'(page_room);
              page_len_nxt = page_calc;
              attempt_nxt = 4'd1; byte_index_nxt = '0; purpose_nxt = W_BEGIN;
              phase_nxt = P_STOP_A;
            end else phase_nxt = P_FINISH;
          end
          P_FINISH: begin
            phase_nxt = P_IDLE; res.done_res = 1'b1; res.failed = fail_r;
            if (!is_read_r) fill_nxt = '0;
          end
          default: phase_nxt = P_IDLE;
        endcase
      end
    end
    res.scl_drive = scl_nxt;
    res.sda_drive = sda_nxt;
    res.busy_res = (phase_nxt != P_IDLE);
  end

  // Address of the buffer byte the next acknowledged byte loads: the same entry
  // after the address byte, the following one during data bytes.
  assign idx_nxt_full = buf_base_r + {4'd0, byte_index_r} +
                        ((stage_r == S_DATA) ? 9'd1 : 9'd0);
  assign rd_idx = idx_nxt_full;

  logic s1_fire;
  assign s1_fire = s1_valid_r;

  i2cee_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_buf (
    .clk, .we(we && s1_fire), .waddr(fill_r[AW-1:0]), .wdata(s1_r.write_byte),
    .raddr(rd_idx[AW-1:0]), .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0; o_valid_r <= 1'b0; k_valid_r <= 1'b0;
      phase_r <= P_IDLE; resume_r <= P_IDLE; stage_r <= S_ID; purpose_r <= W_BEGIN;
      bit_index_r <= '0; attempt_r <= '0; shift_r <= '0; fill_r <= '0;
      byte_index_r <= '0; remaining_r <= '0; page_len_r <= '0; addr_r <= '0;
      wait_r <= '0; buf_base_r <= '0; scl_r <= 1'b1; sda_r <= 1'b1;
      stretch_r <= 1'b0; is_read_r <= 1'b0; fail_r <= 1'b0; nack_r <= 1'b0;
      rd_in_range_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid && in_ready;
      if (in_valid && in_ready) s1_r <= in_data;
      rd_in_range_r <= (idx_nxt_full < 9'(BUFFER_DEPTH));
      if (s1_fire) begin
        phase_r <= phase_nxt; resume_r <= resume_nxt; stage_r <= stage_nxt;
        purpose_r <= purpose_nxt; bit_index_r <= bit_index_nxt;
        attempt_r <= attempt_nxt;
        shift_r <= shift_nxt; fill_r <= fill_nxt; byte_index_r <= byte_index_nxt;
        remaining_r <= remaining_nxt; page_len_r <= page_len_nxt; addr_r <= addr_nxt;
        wait_r <= wait_nxt; buf_base_r <= buf_base_nxt; scl_r <= scl_nxt;
        sda_r <= sda_nxt;
        stretch_r <= stretch_nxt; is_read_r <= is_read_nxt; fail_r <= fail_nxt;
        nack_r <= nack_nxt;
      end
      // Output register with skid slot.
      if (!o_valid_r || out_ready) begin
        if (k_valid_r) begin
          o_r <= k_r; o_valid_r <= 1'b1; k_valid_r <= s1_fire;
          if (s1_fire) k_r <= res;
        end else begin
          o_valid_r <= s1_fire;
          if (s1_fire) o_r <= res;
        end
      end else if (s1_fire) begin
        k_valid_r <= 1'b1; k_r <= res;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/i2cee_checker.sv -----
// Port-level checker for the I2C EEPROM master, bound to the top level.
`default_nettype none
module i2cee_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire i2cee_pkg::out_item_t out_data
);
  import i2cee_pkg::*;
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out beat dropped or changed while stalled");
  a_fail_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.failed |-> out_data.done_res)
    else $error("failed without done");
  a_rv_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.read_valid |-> out_data.read_byte == 8'd0)
    else $error("read byte without valid");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done while busy");
  a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(!rst_n, 2) == 1'b0)
    else $error("out beat without input");
endmodule

bind i2c_eeprom_master_top i2cee_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire
